>>> hdl/cpb_pkg.sv
package cpb_pkg;

	// widths fixed by the item formats
	localparam int CFG_W     = 3;
	localparam int NEIGH_W   = 16;
	localparam int ROW_W     = 19;
	localparam int START_W   = 23;
	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 64;
	localparam int M_TUSER_W = 2;

	// tuser bit positions
	localparam int S_TUSER_HAS_NEIGH = 0;
	localparam int S_TUSER_START     = 1;
	localparam int M_TUSER_LAST_PT   = 0;
	localparam int M_TUSER_OVF       = 1;

	localparam logic [CFG_W-1:0]   DOF_RESET    = CFG_W'(1);
	localparam logic [START_W-1:0] OFFSET_RESET = START_W'(1);

	typedef enum logic {
		FE_COLLECT,
		FE_CLOSE
	} fe_state_t;

	typedef enum logic {
		BE_IDLE,
		BE_RUN
	} be_state_t;

endpackage

>>> hdl/cpb_front.sv
module cpb_front #(
	parameter int MAX_POINTS    = 65536,
	parameter int MAX_NEIGHBORS = 15,
	parameter int MAX_DOF       = 4,
	localparam int PW = $clog2(MAX_POINTS),
	localparam int EW = (PW > cpb_pkg::NEIGH_W) ? PW : cpb_pkg::NEIGH_W,
	localparam int LD = MAX_NEIGHBORS + 1,
	localparam int CW = $clog2(LD + 1),
	localparam int DW = $clog2(MAX_DOF + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [cpb_pkg::CFG_W-1:0]   point_dof,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [cpb_pkg::NEIGH_W-1:0] neighbor_point,
	input  logic                        has_neighbor,
	input  logic                        last_of_point,
	input  logic                        start_matrix,
	output logic                        desc_valid,
	input  logic                        desc_ready,
	output logic [LD-1:0][EW-1:0]       desc_list,
	output logic [CW-1:0]               desc_n,
	output logic [PW-1:0]               desc_pc,
	output logic [cpb_pkg::START_W-1:0] desc_offset,
	output logic [DW-1:0]               desc_d,
	output logic                        desc_ovf
);
	import cpb_pkg::*;

	fe_state_t              state_q, state_nxt;
	logic [LD-1:0][EW-1:0]  list_q;
	logic [LD-1:0][EW-1:0]  ins_list;
	logic [LD-1:0]          le;
	logic [EW-1:0]          ins_val;
	logic [CW-1:0]          cnt_q;
	logic                   ovf_q;
	logic [PW-1:0]          pc_q;
	logic [START_W-1:0]     offset_q;
	logic [DW-1:0]          d_eff;
	logic [CW+DW-1:0]       nd;
	logic                   acc, push, room;

	// dof 0 acts as 1, anything above the maximum is clamped
	always_comb begin
		if (point_dof == '0) begin
			d_eff = DW'(1);
		end else if (int'(point_dof) > MAX_DOF) begin
			d_eff = DW'(MAX_DOF);
		end else begin
			d_eff = DW'(point_dof);
		end
	end

	// single insertion slot into the sorted list: neighbour while collecting,
	// own point index on the close
	always_comb begin
		for (int i = 0; i < LD; i++) begin
			le[i] = (CW'(i) < cnt_q) && (list_q[i] <= ins_val);
		end
		ins_list[0] = le[0] ? list_q[0] : ins_val;
		for (int i = 1; i < LD; i++) begin
			if (le[i]) begin
				ins_list[i] = list_q[i];
			end else if (le[i-1]) begin
				ins_list[i] = ins_val;
			end else begin
				ins_list[i] = list_q[i-1];
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FE_COLLECT: begin
				if (in_valid && last_of_point) begin
					state_nxt = FE_CLOSE;
				end
			end
			FE_CLOSE: begin
				if (desc_ready) begin
					state_nxt = FE_COLLECT;
				end
			end
			default: state_nxt = FE_COLLECT;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == FE_COLLECT);
		desc_valid = (state_q == FE_CLOSE);
		ins_val    = (state_q == FE_COLLECT) ? EW'(neighbor_point) : EW'(pc_q);
	end

	assign acc  = in_valid && in_ready;
	assign push = desc_valid && desc_ready;
	assign room = cnt_q < CW'(MAX_NEIGHBORS);

	assign desc_list   = ins_list;
	assign desc_n      = cnt_q + CW'(1);
	assign desc_pc     = pc_q;
	assign desc_offset = offset_q;
	assign desc_d      = d_eff;
	assign desc_ovf    = ovf_q;
	assign nd          = desc_n * d_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_COLLECT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			pc_q     <= '0;
			offset_q <= OFFSET_RESET;
		end else if (acc) begin
			if (start_matrix) begin
				pc_q     <= '0;
				offset_q <= OFFSET_RESET;
			end
			if (has_neighbor && room) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (has_neighbor) begin
				ovf_q <= 1'b1;
			end
		end else if (push) begin
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			pc_q     <= (pc_q == PW'(MAX_POINTS - 1)) ? '0 : pc_q + PW'(1);
			offset_q <= offset_q + START_W'(nd);
		end
	end

	always_ff @(posedge clk) begin
		if (acc && has_neighbor && room) begin
			list_q <= ins_list;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_NEIGHBORS))
		else $error("neighbour count beyond capacity");

	a_no_take_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last_of_point |=> !in_ready)
		else $error("input taken while closing a point");

endmodule

>>> hdl/cpb_fifo.sv
module cpb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             wr_en, rd_en;

	assign wr_ready = count_q < NW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + NW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(DEPTH))
		else $error("queue fill beyond depth");

endmodule

>>> hdl/cpb_back.sv
module cpb_back #(
	parameter int MAX_POINTS    = 65536,
	parameter int MAX_NEIGHBORS = 15,
	parameter int MAX_DOF       = 4,
	localparam int PW = $clog2(MAX_POINTS),
	localparam int EW = (PW > cpb_pkg::NEIGH_W) ? PW : cpb_pkg::NEIGH_W,
	localparam int LD = MAX_NEIGHBORS + 1,
	localparam int CW = $clog2(LD + 1),
	localparam int IW = $clog2(LD),
	localparam int DW = $clog2(MAX_DOF + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        desc_valid,
	output logic                        desc_ready,
	input  logic [LD-1:0][EW-1:0]       desc_list,
	input  logic [CW-1:0]               desc_n,
	input  logic [PW-1:0]               desc_pc,
	input  logic [cpb_pkg::START_W-1:0] desc_offset,
	input  logic [DW-1:0]               desc_d,
	input  logic                        desc_ovf,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cpb_pkg::ROW_W-1:0]   row_index,
	output logic [cpb_pkg::START_W-1:0] row_start,
	output logic [cpb_pkg::ROW_W-1:0]   col_index,
	output logic                        last_in_row,
	output logic                        last_of_point_res,
	output logic                        overflow
);
	import cpb_pkg::*;

	be_state_t              state_q, state_nxt;
	logic [LD-1:0][EW-1:0]  list_q;
	logic [CW-1:0]          n_q;
	logic [DW-1:0]          d_q, k_q;
	logic [IW-1:0]          i_q;
	logic [ROW_W-1:0]       row_q;
	logic [START_W-1:0]     start_q;
	logic                   ovf_q;
	logic [PW+DW-1:0]       row_prod;
	logic [EW+DW-1:0]       col_prod;
	logic [ROW_W-1:0]       col_nxt;
	logic                   i_last, k_last, adv, emit, load;

	logic                   out_valid_q;
	logic [ROW_W-1:0]       row_out_q, col_out_q;
	logic [START_W-1:0]     start_out_q;
	logic                   lir_q, lpr_q, ovf_out_q;

	assign i_last   = (CW'(i_q) == n_q - CW'(1));
	assign k_last   = (k_q == d_q - DW'(1));
	assign adv      = !out_valid_q || out_ready;
	assign row_prod = desc_pc * desc_d;
	assign col_prod = list_q[i_q] * d_q;
	assign col_nxt  = ROW_W'(col_prod) + ROW_W'(k_q) + ROW_W'(1);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BE_IDLE: begin
				if (desc_valid) begin
					state_nxt = BE_RUN;
				end
			end
			BE_RUN: begin
				if (adv && i_last && k_last) begin
					state_nxt = BE_IDLE;
				end
			end
			default: state_nxt = BE_IDLE;
		endcase
	end

	always_comb begin
		desc_ready = (state_q == BE_IDLE);
		load       = desc_ready && desc_valid;
		emit       = (state_q == BE_RUN) && adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BE_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	// row walker: i steps over the sorted points, k over the expanded rows
	always_ff @(posedge clk) begin
		if (load) begin
			list_q  <= desc_list;
			n_q     <= desc_n;
			d_q     <= desc_d;
			ovf_q   <= desc_ovf;
			row_q   <= ROW_W'(row_prod) + ROW_W'(1);
			start_q <= desc_offset;
			k_q     <= '0;
			i_q     <= '0;
		end else if (emit) begin
			if (i_last) begin
				i_q     <= '0;
				k_q     <= k_q + DW'(1);
				row_q   <= row_q + ROW_W'(1);
				start_q <= start_q + START_W'(n_q);
			end else begin
				i_q <= i_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			row_out_q   <= row_q;
			start_out_q <= start_q;
			col_out_q   <= col_nxt;
			lir_q       <= i_last;
			lpr_q       <= i_last && k_last;
			ovf_out_q   <= ovf_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign row_index         = row_out_q;
	assign row_start         = start_out_q;
	assign col_index         = col_out_q;
	assign last_in_row       = lir_q;
	assign last_of_point_res = lpr_q;
	assign overflow          = ovf_out_q;

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BE_RUN |-> (CW'(i_q) < n_q) && (k_q < d_q))
		else $error("row walker out of range");

	a_point_end_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && lpr_q |-> lir_q)
		else $error("point closed off a row end");

endmodule

>>> hdl/block_csr_pattern_builder_top.sv
// Channel | Dir | Payload (lowest bit first)                            | Accepted when
// s_*     | in  | tdata: neighbor_point[15:0]; tuser: has_neighbor,     | s_tvalid & s_tready
//         |     |   start_matrix; tlast: last_of_point                  |
// m_*     | out | tdata: row_index, row_start, col_index, 3 zero bits;  | m_tvalid & m_tready
//         |     |   tuser: last_of_point_res, overflow; tlast: last_in_row
// cfg_*   | in  | cfg_data: point_dof[2:0]                              | cfg_valid & cfg_ready
//
// Neighbour transactions are accepted while collecting. A closing transaction holds off the input
// while the point's own index is inserted and the point is queued, and for as long as the
// two-entry queue is full. Neighbours are kept sorted by insertion as they arrive.
// The back end loads a point, then emits n*d results at one per cycle while m_tready allows, with
// n = neighbours kept + 1; this row walk sets the throughput of a point.
// Reset (arst_n, async, low) returns dof to 1, offset to 1 and the point counter to 0.
// A stalled output holds the walker only; the front keeps collecting until the queue fills.
module block_csr_pattern_builder_top #(
	parameter int MAX_POINTS    = 65536,
	parameter int MAX_NEIGHBORS = 15,
	parameter int MAX_DOF       = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cpb_pkg::S_TDATA_W-1:0] s_tdata,  // neighbor_point[15:0]
	input  logic [cpb_pkg::S_TUSER_W-1:0] s_tuser,  // [0] has_neighbor, [1] start_matrix
	input  logic                          s_tlast,  // last_of_point
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cpb_pkg::M_TDATA_W-1:0] m_tdata,  // [18:0] row_index, [41:19] row_start,
	                                                // [60:42] col_index, [63:61] zero
	output logic [cpb_pkg::M_TUSER_W-1:0] m_tuser,  // [0] last_of_point_res, [1] overflow
	output logic                          m_tlast,  // last_in_row
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cpb_pkg::CFG_W-1:0]     cfg_data  // point_dof
);
	import cpb_pkg::*;

	localparam int PW     = $clog2(MAX_POINTS);
	localparam int EW     = (PW > NEIGH_W) ? PW : NEIGH_W;
	localparam int LD     = MAX_NEIGHBORS + 1;
	localparam int CW     = $clog2(LD + 1);
	localparam int DW     = $clog2(MAX_DOF + 1);
	localparam int DESC_W = LD * EW + CW + PW + START_W + DW + 1;
	localparam int QDEPTH = 2;

	logic [CFG_W-1:0]       point_dof_q;

	// front -> queue
	logic                   f_valid, f_ready;
	logic [LD-1:0][EW-1:0]  f_list;
	logic [CW-1:0]          f_n;
	logic [PW-1:0]          f_pc;
	logic [START_W-1:0]     f_offset;
	logic [DW-1:0]          f_d;
	logic                   f_ovf;

	// queue -> back
	logic                   b_valid, b_ready;
	logic [LD-1:0][EW-1:0]  b_list;
	logic [CW-1:0]          b_n;
	logic [PW-1:0]          b_pc;
	logic [START_W-1:0]     b_offset;
	logic [DW-1:0]          b_d;
	logic                   b_ovf;
	logic [DESC_W-1:0]      q_wdata, q_rdata;

	logic [ROW_W-1:0]       row_index, col_index;
	logic [START_W-1:0]     row_start;
	logic                   last_in_row, last_of_point_res, overflow;

	// dof register: always ready; the user must write it only while the block is idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_dof_q <= DOF_RESET;
		end else if (cfg_valid) begin
			point_dof_q <= cfg_data;
		end
	end

	cpb_front #(
		.MAX_POINTS    (MAX_POINTS),
		.MAX_NEIGHBORS (MAX_NEIGHBORS),
		.MAX_DOF       (MAX_DOF)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.point_dof      (point_dof_q),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.neighbor_point (s_tdata[NEIGH_W-1:0]),
		.has_neighbor   (s_tuser[S_TUSER_HAS_NEIGH]),
		.last_of_point  (s_tlast),
		.start_matrix   (s_tuser[S_TUSER_START]),
		.desc_valid     (f_valid),
		.desc_ready     (f_ready),
		.desc_list      (f_list),
		.desc_n         (f_n),
		.desc_pc        (f_pc),
		.desc_offset    (f_offset),
		.desc_d         (f_d),
		.desc_ovf       (f_ovf)
	);

	// one queue entry is a whole closed point: sorted list plus its row parameters
	assign q_wdata = {f_list, f_n, f_pc, f_offset, f_d, f_ovf};
	assign {b_list, b_n, b_pc, b_offset, b_d, b_ovf} = q_rdata;

	cpb_fifo #(
		.WIDTH (DESC_W),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (q_wdata),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (q_rdata)
	);

	cpb_back #(
		.MAX_POINTS    (MAX_POINTS),
		.MAX_NEIGHBORS (MAX_NEIGHBORS),
		.MAX_DOF       (MAX_DOF)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.desc_valid        (b_valid),
		.desc_ready        (b_ready),
		.desc_list         (b_list),
		.desc_n            (b_n),
		.desc_pc           (b_pc),
		.desc_offset       (b_offset),
		.desc_d            (b_d),
		.desc_ovf          (b_ovf),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.row_index         (row_index),
		.row_start         (row_start),
		.col_index         (col_index),
		.last_in_row       (last_in_row),
		.last_of_point_res (last_of_point_res),
		.overflow          (overflow)
	);

	assign m_tdata = M_TDATA_W'({col_index, row_start, row_index});
	assign m_tlast = last_in_row;
	always_comb begin
		m_tuser                  = '0;
		m_tuser[M_TUSER_LAST_PT] = last_of_point_res;
		m_tuser[M_TUSER_OVF]     = overflow;
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

// Checks block_csr_pattern_builder_top against a predictor of its own.
// Adjacency transactions go in on s_*. Every accepted one is fed to the
// predictor, which queues the nonzeros that a closing point should produce.
// Every m_* transaction is checked field by field against the oldest queued
// nonzero. The tests run in turn: directed cases, overflow, every dof code
// and a random phase that tops the run up to its transaction budget.
module tb;
	import cpb_pkg::*;

	localparam int MAX_PTS    = 65536;
	localparam int MAX_NB     = 15;
	localparam int DOF_CAP    = 4;
	localparam int SETTLE     = 32;   // front end can still hold a point when the queue empties
	localparam int STALL_LIM  = 2000; // cycles with no transaction on any channel
	localparam int REPORT_CAP = 100;  // keeps the log short when the block is badly broken
	localparam int N_ITEMS    = 460;  // input transactions over the whole run
	localparam int PAD_LO     = 2 * ROW_W + START_W;

	// one expected nonzero of the pattern
	typedef struct packed {
		logic [ROW_W-1:0]   row_index;
		logic [START_W-1:0] row_start;
		logic [ROW_W-1:0]   col_index;
		logic               last_in_row;
		logic               last_of_point;
		logic               dropped;
	} nonzero_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;  // neighbor_point
	logic [S_TUSER_W-1:0] s_tuser   = '0;  // [0] has_neighbor, [1] start_matrix
	logic                 s_tlast   = 1'b0; // last_of_point
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;  // row_index, row_start, col_index, zero pad
	logic [M_TUSER_W-1:0] m_tuser;  // [0] last_of_point_res, [1] overflow
	logic                 m_tlast;  // last_in_row
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// predictor state
	logic [NEIGH_W-1:0] cur_point  = '0;
	logic [START_W-1:0] next_start = OFFSET_RESET;
	logic [NEIGH_W-1:0] held_nb[$];
	bit                 nb_dropped = 1'b0;
	logic [CFG_W-1:0]   dof_reg    = DOF_RESET;

	nonzero_t due_nonzeros[$];
	int       err_cnt = 0;
	int       quiet   = 0;
	int       sent    = 0;    // input transactions accepted so far
	bit       no_idle = 1'b0; // set for a stretch in which neither side idles

	block_csr_pattern_builder_top #(
		.MAX_POINTS(MAX_PTS),
		.MAX_NEIGHBORS(MAX_NB),
		.MAX_DOF(DOF_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predictor: restart first, then collection, then the close. On a close the
	// own index joins the held neighbours, the lot is sorted, and d rows of n
	// nonzeros are queued.
	function automatic void take_adjacency(input logic [NEIGH_W-1:0] nb, input bit has,
			input bit close, input bit restart);
		logic [NEIGH_W-1:0] pts[$];
		nonzero_t nz;
		int d;
		int n;
		if (restart) begin
			cur_point  = '0;
			next_start = OFFSET_RESET;
		end
		if (has) begin
			if (held_nb.size() < MAX_NB)
				held_nb.push_back(nb);
			else
				nb_dropped = 1'b1;
		end
		if (!close)
			return;
		pts = held_nb;
		pts.push_back(cur_point);
		pts.sort();
		n = pts.size();
		// codes 0 and above the cap are clamped
		d = (dof_reg == '0) ? 1 : (int'(dof_reg) > DOF_CAP) ? DOF_CAP : int'(dof_reg);
		for (int k = 0; k < d; k++) begin
			for (int i = 0; i < n; i++) begin
				nz.row_index     = ROW_W'(int'(cur_point) * d + k + 1);
				nz.row_start     = next_start;
				nz.col_index     = ROW_W'(int'(pts[i]) * d + k + 1);
				nz.last_in_row   = (i == n - 1);
				nz.last_of_point = (i == n - 1) && (k == d - 1);
				nz.dropped       = nb_dropped;
				due_nonzeros.push_back(nz);
			end
			next_start = next_start + START_W'(n);
		end
		held_nb.delete();
		nb_dropped = 1'b0;
		cur_point  = cur_point + 1'b1; // wraps at MAX_PTS
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			err_cnt++;
			if (err_cnt <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endfunction

	// Sender: random idle cycles, then holds the transaction until accepted.
	// tvalid is never lowered here after a handshake; the next call, an idle
	// cycle or drain() does that, so each step sees one assignment.
	task automatic push_adjacency(input logic [NEIGH_W-1:0] nb, input bit has,
			input bit close, input bit restart);
		while (!no_idle && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid                   <= 1'b1;
		s_tdata                    <= nb;
		s_tuser[S_TUSER_HAS_NEIGH] <= has;
		s_tuser[S_TUSER_START]     <= restart;
		s_tlast                    <= close;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		take_adjacency(nb, has, close, restart);
	endtask

	// Sender pauses until every queued nonzero has come, then lets the front settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (due_nonzeros.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Only called after drain(), with no neighbours held.
	task automatic write_dof(input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		dof_reg = val;
	endtask

	// a neighbour index: fully random, or near the current point for tight sorts
	function automatic logic [NEIGH_W-1:0] pick_neighbour();
		if ($urandom_range(1))
			return NEIGH_W'($urandom);
		return cur_point + NEIGH_W'($urandom_range(8)) - NEIGH_W'(4);
	endfunction

	// one point: n neighbours, closed on the last one or by a bare close
	task automatic push_point(input int n, input bit restart_first);
		bit close_on_last;
		close_on_last = (n > 0) && $urandom_range(1);
		for (int i = 0; i < n; i++)
			push_adjacency(pick_neighbour(), 1'b1, close_on_last && i == n - 1,
				restart_first && i == 0);
		if (!close_on_last)
			push_adjacency(NEIGH_W'($urandom), 1'b0, 1'b1, restart_first && n == 0);
	endtask

	// Extremes of the index, sorting, close with a neighbour, duplicates,
	// restarts and a transaction that causes nothing. Dof is still at reset.
	task automatic test_directed();
		push_adjacency(16'hFFFF, 1'b0, 1'b1, 1'b0); // lone point, data ignored
		push_adjacency(16'hFFFF, 1'b1, 1'b0, 1'b0);
		push_adjacency(16'h0000, 1'b1, 1'b0, 1'b0);
		push_adjacency(16'h8000, 1'b1, 1'b0, 1'b0);
		push_adjacency(16'h1234, 1'b0, 1'b1, 1'b0);
		push_adjacency(16'h0002, 1'b1, 1'b1, 1'b0); // neighbour and close together
		push_adjacency(16'h0005, 1'b1, 1'b0, 1'b0); // repeated columns
		push_adjacency(16'h0005, 1'b1, 1'b0, 1'b0);
		push_adjacency(16'h0005, 1'b1, 1'b1, 1'b0);
		push_adjacency(16'h0007, 1'b1, 1'b0, 1'b0); // restart keeps the held neighbour
		push_adjacency(16'h0003, 1'b1, 1'b0, 1'b1);
		push_adjacency(16'h5A5A, 1'b0, 1'b1, 1'b0);
		push_adjacency(16'h0009, 1'b1, 1'b1, 1'b1); // restart and close at once
		push_adjacency(16'hA5A5, 1'b0, 1'b0, 1'b0); // no close, no result
		drain();
	endtask

	// Two neighbours too many, the second with a restart that keeps the flag, then a clean point.
	task automatic test_overflow();
		for (int i = 0; i < MAX_NB; i++)
			push_adjacency(NEIGH_W'(i * 4099), 1'b1, 1'b0, 1'b0);
		push_adjacency(16'h7FFF, 1'b1, 1'b0, 1'b0);
		push_adjacency(16'h0001, 1'b1, 1'b0, 1'b1);
		push_adjacency(16'hFFFE, 1'b0, 1'b1, 1'b0);
		push_adjacency(16'h0004, 1'b1, 1'b1, 1'b0);
		drain();
	endtask

	// All dof codes, including 0 and those above the cap; full rows at the extremes.
	task automatic test_dof_codes();
		logic [CFG_W-1:0] codes[8] = '{3'd0, 3'd5, 3'd2, 3'd7, 3'd1, 3'd3, 3'd6, 3'd4};
		foreach (codes[c]) begin
			write_dof(codes[c]);
			push_point((codes[c] == 3'd4 || codes[c] == 3'd7) ? MAX_NB : int'(codes[c]),
				c == 0);
			drain();
		end
	endtask

	// Mostly well-formed points with random content, some noise transactions and
	// restarts, occasional dof changes, one pause for the queue to empty, and a
	// stretch with no idling on either side. Runs until the budget is spent.
	task automatic test_random();
		int  n;
		int  r;
		bit  paused;
		paused = 1'b0;
		while (sent < N_ITEMS) begin
			no_idle = (sent >= 200 && sent < 320);
			if (!paused && sent >= 340) begin
				drain();
				paused = 1'b1;
			end
			if ($urandom_range(99) < 4) begin
				drain();
				write_dof(CFG_W'($urandom_range(7)));
			end
			if ($urandom_range(99) < 12) begin
				// noise: no neighbour, no close, sometimes a restart
				push_adjacency(NEIGH_W'($urandom), 1'b0, 1'b0, $urandom_range(3) == 0);
			end else begin
				r = $urandom_range(99);
				n = (r < 50) ? $urandom_range(4) :
				    (r < 85) ? $urandom_range(14, 5) :
				    (r < 95) ? MAX_NB : $urandom_range(MAX_NB + 4, MAX_NB + 1);
				push_point(n, $urandom_range(99) < 5);
			end
		end
		no_idle = 1'b0;
		drain();
	endtask

	// receiver back-pressure
	always @(posedge clk)
		m_tready <= no_idle || ($urandom_range(99) >= 11);

	// result checker
	always @(posedge clk) begin
		nonzero_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_nonzeros.size() == 0) begin
				err_cnt++;
				if (err_cnt <= REPORT_CAP)
					$display("%0t: unexpected result, expected none, actual tdata %h",
						$time, m_tdata);
			end else begin
				want = due_nonzeros.pop_front();
				check_field("row_index", want.row_index, m_tdata[ROW_W-1:0]);
				check_field("row_start", want.row_start, m_tdata[ROW_W+START_W-1:ROW_W]);
				check_field("col_index", want.col_index, m_tdata[PAD_LO-1:ROW_W+START_W]);
				check_field("tdata pad", 0, m_tdata[M_TDATA_W-1:PAD_LO]);
				check_field("last_in_row", want.last_in_row, m_tlast);
				check_field("last_of_point_res", want.last_of_point, m_tuser[M_TUSER_LAST_PT]);
				check_field("overflow", want.dropped, m_tuser[M_TUSER_OVF]);
			end
		end
	end

	// watchdog: too long with no transaction on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet <= 0;
			end else if (quiet >= STALL_LIM) begin
				$display("block_csr_pattern_builder_top verification failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_dof_codes();
		test_random();
		repeat (SETTLE) @(posedge clk);
		if (err_cnt == 0) begin
			$display("block_csr_pattern_builder_top verification clean");
		end else begin
			$display("block_csr_pattern_builder_top verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/cpb_pkg.sv
hdl/cpb_front.sv
hdl/cpb_fifo.sv
hdl/cpb_back.sv
hdl/block_csr_pattern_builder_top.sv
tb/tb.sv
